// ===== design/xor_checked_frame_deframer_macros.svh =====
// Assertion macros shared by the deframer checker.
// Needs aclk and aresetn in the scope where the macros are used.
`ifndef XOR_CHECKED_FRAME_DEFRAMER_MACROS_SVH
`define XOR_CHECKED_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication or plain property, clocked on aclk.
`define XCFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Next-cycle implication, clocked on aclk.
`define XCFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/xcfd_pkg.sv =====
// Types and constants for the XOR-checked frame deframer.
// No dependencies; used by the top level and its checker.
`default_nettype none

package xcfd_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_GOOD   = 2'd1;
    localparam logic [1:0] KIND_ZEROLN = 2'd2;
    localparam logic [1:0] KIND_BADSUM = 2'd3;

    // Register map, selected by paddr[2]
    localparam logic REG_START_FIRST  = 1'b0;
    localparam logic REG_START_SECOND = 1'b1;

    localparam logic [7:0] START_FIRST_RST  = 8'haa;
    localparam logic [7:0] START_SECOND_RST = 8'h55;

    typedef enum logic [5:0] {
        PH_SOF_A    = 6'b000001,
        PH_SOF_B    = 6'b000010,
        PH_LENGTH   = 6'b000100,
        PH_CMD      = 6'b001000,
        PH_PAYLOAD  = 6'b010000,
        PH_CHECK    = 6'b100000
    } phase_t;

endpackage

`default_nettype wire

// ===== design/xor_checked_frame_deframer.sv =====
// XOR-checked frame deframer: start-byte hunt, length/command parse, running XOR check.
// A byte on s_rx_byte reaches the m_ ports through the input reg and the result reg;
// the parser step sits between them. Throughput: one byte per cycle while the result
// slot is free. Reset (aresetn low, synchronous): hunt for first start byte, both stages
// empty, start bytes back to 0xaa and 0x55. Depends on xcfd_pkg.
`default_nettype none

module xor_checked_frame_deframer
    import xcfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_command,
    output logic [7:0]  m_data_byte,
    output logic [7:0]  m_frame_pos
);

    logic [7:0] start_first_reg;
    logic [7:0] start_second_reg;
    logic       cfg_write;
    logic [7:0] cfg_rd;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_free;
    logic       step;

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] chk_reg, chk_next;
    logic [7:0] len_minus1;
    logic [7:0] cnt_plus1;

    logic       emit;
    logic [1:0] e_kind;
    logic [7:0] e_cmd;
    logic [7:0] e_data;
    logic [7:0] e_len;

    logic       m_valid_reg;
    logic [1:0] m_kind_reg;
    logic [7:0] m_command_reg;
    logic [7:0] m_data_byte_reg;
    logic [7:0] m_frame_pos_reg;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_first_reg  <= START_FIRST_RST;
            start_second_reg <= START_SECOND_RST;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_START_FIRST:  start_first_reg  <= pwdata[7:0];
                REG_START_SECOND: start_second_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_START_FIRST:  cfg_rd = start_first_reg;
            REG_START_SECOND: cfg_rd = start_second_reg;
            default:          cfg_rd = 8'd0;
        endcase
    end
    assign prdata = {24'd0, cfg_rd};

    // Pipeline control: the input stage advances whenever the result slot is free
    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    // Parser step
    assign len_minus1 = 8'(len_reg - 8'd1);
    assign cnt_plus1  = 8'(cnt_reg + 8'd1);

    always_comb begin
        phase_next = PH_SOF_A;
        len_next   = len_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        chk_next   = chk_reg;
        emit       = 1'b0;
        e_kind     = KIND_DATA;
        e_cmd      = 8'd0;
        e_data     = 8'd0;
        e_len      = 8'd0;
        case (phase_reg)
            PH_SOF_B: begin
                // a wrong second byte is not retried as a first start byte
                phase_next = (in_byte_reg == start_second_reg) ? PH_LENGTH : PH_SOF_A;
            end
            PH_LENGTH: begin
                len_next = in_byte_reg;
                if (in_byte_reg == 8'd0) begin
                    emit       = 1'b1;
                    e_kind     = KIND_ZEROLN;
                    phase_next = PH_SOF_A;
                end else begin
                    phase_next = PH_CMD;
                end
            end
            PH_CMD: begin
                cmd_next   = in_byte_reg;
                cnt_next   = 8'd0;
                chk_next   = len_reg ^ in_byte_reg;
                phase_next = (len_reg == 8'd1) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                emit       = 1'b1;
                e_kind     = KIND_DATA;
                e_cmd      = cmd_reg;
                e_data     = in_byte_reg;
                e_len      = cnt_reg;
                chk_next   = chk_reg ^ in_byte_reg;
                cnt_next   = cnt_plus1;
                phase_next = (cnt_plus1 == len_minus1) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_CHECK: begin
                emit       = 1'b1;
                e_kind     = (in_byte_reg == chk_reg) ? KIND_GOOD : KIND_BADSUM;
                e_cmd      = cmd_reg;
                e_len      = len_minus1;
                phase_next = PH_SOF_A;
            end
            default: begin
                phase_next = (in_byte_reg == start_first_reg) ? PH_SOF_B : PH_SOF_A;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SOF_A;
            len_reg   <= 8'd0;
            cmd_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            chk_reg   <= 8'd0;
        end else if (step) begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            chk_reg   <= chk_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            m_kind_reg      <= e_kind;
            m_command_reg   <= e_cmd;
            m_data_byte_reg <= e_data;
            m_frame_pos_reg <= e_len;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_command   = m_command_reg;
    assign m_data_byte = m_data_byte_reg;
    assign m_frame_pos = m_frame_pos_reg;

endmodule

`default_nettype wire

// ===== design/xcfd_checker.sv =====
// Port-level checker for the deframer result channel, bound to the top level.
// Depends on xcfd_pkg and xor_checked_frame_deframer_macros.svh.
`default_nettype none
`include "xor_checked_frame_deframer_macros.svh"

module xcfd_checker
    import xcfd_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [1:0] m_kind,
    input wire logic [7:0] m_command,
    input wire logic [7:0] m_data_byte,
    input wire logic [7:0] m_frame_pos
);

    logic [25:0] result_bits;
    logic        stall;
    logic        frame_end;
    logic        zero_len;
    logic        zero_fields;

    assign result_bits = {m_kind, m_command, m_data_byte, m_frame_pos};
    assign stall       = m_valid && !m_ready;
    assign frame_end   = m_valid && (m_kind != KIND_DATA);
    assign zero_len    = m_valid && (m_kind == KIND_ZEROLN);
    assign zero_fields = ({m_command, m_frame_pos} == 16'd0);

    // hold a stalled result
    `XCFD_ASSERT_NEXT(a_stall_hold, stall, m_valid && $stable(result_bits), "stalled result changed")

    `XCFD_ASSERT(a_frame_end_no_data, frame_end |-> m_data_byte == 8'd0, "data byte set on frame end")

    `XCFD_ASSERT(a_zero_len_fields, zero_len |-> zero_fields, "zero length error carries frame fields")

    // payload length never exceeds 254
    `XCFD_ASSERT(a_len_range, m_valid |-> m_frame_pos != 8'hff, "payload length out of range")

endmodule

bind xor_checked_frame_deframer xcfd_checker u_xcfd_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kind      (m_kind),
    .m_command   (m_command),
    .m_data_byte (m_data_byte),
    .m_frame_pos (m_frame_pos)
);

`default_nettype wire
